// ----- rtl/clkm_pkg.sv -----
// ----------------------------------------------------------------------------
// clkm_pkg
// Shared types, constants and keyword table of the command line keyword
// matcher.
// ----------------------------------------------------------------------------
`default_nettype none

package clkm_pkg;

   localparam int LINE_CAPACITY = 64;
   localparam int COMMAND_COUNT = 5;
   localparam int MAX_RESULTS   = 64;
   localparam int KEYWORD_TOTAL = 5;
   localparam int KW_MAX_LEN    = 10;

   localparam int KW_IDX_W  = 3;
   localparam int KW_POS_W  = 4;
   localparam int ID_W      = 3;
   localparam int CNT_W     = $clog2(MAX_RESULTS + 1);

   // entries actually searched
   localparam int KW_ACTIVE = (KEYWORD_TOTAL < COMMAND_COUNT) ? KEYWORD_TOTAL : COMMAND_COUNT;

   localparam logic [ID_W-1:0]     UNKNOWN_ID = ID_W'(COMMAND_COUNT);
   localparam logic [KW_IDX_W-1:0] KW_LAST    = KW_IDX_W'(KW_ACTIVE - 1);

   localparam logic [7:0] CHAR_NUL   = 8'd0;
   localparam logic [7:0] CHAR_TAB   = 8'd9;
   localparam logic [7:0] CHAR_LF    = 8'd10;
   localparam logic [7:0] CHAR_CR    = 8'd13;
   localparam logic [7:0] CHAR_SPACE = 8'd32;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_KW_CHECK,
      ST_KW_CMP,
      ST_SKIP_CHECK,
      ST_SKIP_CMP,
      ST_EMIT_READ,
      ST_EMIT_LOAD,
      ST_EMPTY
   } seq_state_type;

   // keyword text, left-justified, zero padded
   function automatic logic [KW_MAX_LEN*8-1:0] kw_text(input logic [KW_IDX_W-1:0] k);
      logic [KW_MAX_LEN*8-1:0] t;
      case (k)
         3'd0:    t = {"*IDN?", 40'h0};
         3'd1:    t = {"LED", 56'h0};
         3'd2:    t = "STEP:DELAY";
         3'd3:    t = {"STEP:INIT", 8'h0};
         3'd4:    t = {"HELP", 48'h0};
         default: t = '0;
      endcase
      return t;
   endfunction

   function automatic logic [KW_POS_W-1:0] kw_len(input logic [KW_IDX_W-1:0] k);
      logic [KW_POS_W-1:0] n;
      case (k)
         3'd0:    n = 4'd5;
         3'd1:    n = 4'd3;
         3'd2:    n = 4'd10;
         3'd3:    n = 4'd9;
         3'd4:    n = 4'd4;
         default: n = 4'd0;
      endcase
      return n;
   endfunction

   function automatic logic [7:0] kw_char(input logic [KW_IDX_W-1:0] k,
                                          input logic [KW_POS_W-1:0] i);
      logic [KW_MAX_LEN*8-1:0] t;
      t = kw_text(k) << (8 * int'(i));
      return t[KW_MAX_LEN*8-1 -: 8];
   endfunction

   function automatic logic [7:0] fold_case(input logic [7:0] c);
      logic [7:0] r;
      r = c;
      if (c >= 8'd97 && c <= 8'd122) begin
         r = c - 8'd32;
      end
      return r;
   endfunction

endpackage

`default_nettype wire

// ----- rtl/command_line_keyword_matcher_unit.sv -----
// ----------------------------------------------------------------------------
// command_line_keyword_matcher_unit
// Collects received bytes into a line store and, at each line end, reports
// the matched keyword and the argument characters.
//
//   channel  dir  handshake              payload
//   req      in   req_valid/req_stall    req_rx_byte
//   rsp      out  rsp_valid/rsp_stall    rsp_command_id, rsp_arg_char,
//                                        rsp_char_valid, rsp_last
//
// An ordinary byte is written to the store when accepted. After a line end
// the block stalls req while one shared compare unit works through the store:
// each keyword character compared, skipped blank and emitted item is a store
// read, then a step on the registered data. rsp_stall holds the sequencer.
// Reset is synchronous; the line store is not cleared.
// ----------------------------------------------------------------------------
`default_nettype none

module command_line_keyword_matcher_unit #(
   parameter int LINE_CAPACITY = clkm_pkg::LINE_CAPACITY,
   localparam int PW = $clog2(LINE_CAPACITY)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      req_valid,
   output logic                           req_stall,
   input  wire logic [7:0]                req_rx_byte,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [clkm_pkg::ID_W-1:0]      rsp_command_id,
   output logic [7:0]                     rsp_arg_char,
   output logic                           rsp_char_valid,
   output logic                           rsp_last
);

   logic [PW-1:0] wpos_ff, wpos_in;
   logic          busy;
   logic          accept;
   logic          is_end;
   logic          wr_en;
   logic          start;
   logic          rd_en;
   logic [PW-1:0] rd_addr;
   logic [7:0]    rd_data;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;
   assign is_end    = (req_rx_byte == clkm_pkg::CHAR_LF) || (req_rx_byte == clkm_pkg::CHAR_CR) ||
                      (req_rx_byte == clkm_pkg::CHAR_NUL);
   assign wr_en     = accept && !is_end;
   assign start     = accept && is_end && (wpos_ff != '0);

   always_comb begin
      wpos_in = wpos_ff;
      if (accept) begin
         if (is_end) begin
            wpos_in = '0;
         end else if (wpos_ff == PW'(LINE_CAPACITY - 1)) begin
            // store full: drop the line
            wpos_in = '0;
         end else begin
            wpos_in = wpos_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wpos_ff <= '0;
      end else begin
         wpos_ff <= wpos_in;
      end
   end

   clkm_store #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wpos_ff),
      .wr_data (req_rx_byte),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   clkm_seq #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_seq (
      .clock          (clock),
      .reset          (reset),
      .start          (start),
      .line_len       (wpos_ff),
      .busy           (busy),
      .rd_en          (rd_en),
      .rd_addr        (rd_addr),
      .rd_data        (rd_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_command_id (rsp_command_id),
      .rsp_arg_char   (rsp_arg_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ----- rtl/clkm_store.sv -----
// ----------------------------------------------------------------------------
// clkm_store
// Line store: one write port, one registered read port.
// ----------------------------------------------------------------------------
`default_nettype none

module clkm_store #(
   parameter int LINE_CAPACITY = clkm_pkg::LINE_CAPACITY,
   localparam int PW = $clog2(LINE_CAPACITY)
) (
   input  wire logic          clock,
   input  wire logic          wr_en,
   input  wire logic [PW-1:0] wr_addr,
   input  wire logic [7:0]    wr_data,
   input  wire logic          rd_en,
   input  wire logic [PW-1:0] rd_addr,
   output logic [7:0]         rd_data
);

   logic [7:0] store_ff [LINE_CAPACITY];
   logic [7:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         store_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= store_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ----- rtl/clkm_seq.sv -----
// ----------------------------------------------------------------------------
// clkm_seq
// Match and emit sequencer: walks the keyword table one character per
// compare, skips blanks, then streams the argument through the output register.
// ----------------------------------------------------------------------------
`default_nettype none

module clkm_seq #(
   parameter int LINE_CAPACITY = clkm_pkg::LINE_CAPACITY,
   localparam int PW = $clog2(LINE_CAPACITY)
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire logic [PW-1:0]             line_len,
   output logic                           busy,
   output logic                           rd_en,
   output logic [PW-1:0]                  rd_addr,
   input  wire logic [7:0]                rd_data,
   output logic                           rsp_valid,
   input  wire logic                      rsp_stall,
   output logic [clkm_pkg::ID_W-1:0]      rsp_command_id,
   output logic [7:0]                     rsp_arg_char,
   output logic                           rsp_char_valid,
   output logic                           rsp_last
);

   localparam int CMPW = (PW > clkm_pkg::KW_POS_W) ? PW : clkm_pkg::KW_POS_W;

   clkm_pkg::seq_state_type state_ff, state_in;
   logic [clkm_pkg::KW_IDX_W-1:0] k_ff, k_in;
   logic [clkm_pkg::KW_POS_W-1:0] i_ff, i_in;
   logic [PW-1:0]                 pos_ff, pos_in;
   logic [PW-1:0]                 len_ff, len_in;
   logic [clkm_pkg::CNT_W-1:0]    cnt_ff, cnt_in;
   logic [clkm_pkg::ID_W-1:0]     id_ff, id_in;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic [clkm_pkg::ID_W-1:0]     rsp_id_ff, rsp_id_in;
   logic [7:0]                    rsp_char_ff, rsp_char_in;
   logic                          rsp_cv_ff, rsp_cv_in;
   logic                          rsp_last_ff, rsp_last_in;

   logic                          out_free;
   logic                          emit_last;
   logic                          char_eq;
   logic                          is_blank;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign char_eq   = clkm_pkg::fold_case(rd_data) ==
                      clkm_pkg::fold_case(clkm_pkg::kw_char(k_ff, i_ff));
   assign is_blank  = (rd_data == clkm_pkg::CHAR_SPACE) || (rd_data == clkm_pkg::CHAR_TAB);
   assign emit_last = ({1'b0, pos_ff} + 1'b1 == {1'b0, len_ff}) ||
                      (cnt_ff == clkm_pkg::CNT_W'(clkm_pkg::MAX_RESULTS - 1));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= clkm_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      k_ff        <= k_in;
      i_ff        <= i_in;
      pos_ff      <= pos_in;
      len_ff      <= len_in;
      cnt_ff      <= cnt_in;
      id_ff       <= id_in;
      rsp_id_ff   <= rsp_id_in;
      rsp_char_ff <= rsp_char_in;
      rsp_cv_ff   <= rsp_cv_in;
      rsp_last_ff <= rsp_last_in;
   end

   always_comb begin
      state_in     = state_ff;
      k_in         = k_ff;
      i_in         = i_ff;
      pos_in       = pos_ff;
      len_in       = len_ff;
      cnt_in       = cnt_ff;
      id_in        = id_ff;
      rd_en        = 1'b0;
      rd_addr      = pos_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      rsp_id_in    = rsp_id_ff;
      rsp_char_in  = rsp_char_ff;
      rsp_cv_in    = rsp_cv_ff;
      rsp_last_in  = rsp_last_ff;

      case (state_ff)
         clkm_pkg::ST_IDLE: begin
            if (start) begin
               len_in   = line_len;
               k_in     = '0;
               i_in     = '0;
               cnt_in   = '0;
               state_in = clkm_pkg::ST_KW_CHECK;
            end
         end
         clkm_pkg::ST_KW_CHECK: begin
            if (i_ff == clkm_pkg::kw_len(k_ff)) begin
               id_in    = clkm_pkg::ID_W'(k_ff);
               pos_in   = PW'(i_ff);
               state_in = clkm_pkg::ST_SKIP_CHECK;
            end else if (CMPW'(i_ff) >= CMPW'(len_ff)) begin
               if (k_ff == clkm_pkg::KW_LAST) begin
                  id_in    = clkm_pkg::UNKNOWN_ID;
                  pos_in   = '0;
                  state_in = clkm_pkg::ST_EMIT_READ;
               end else begin
                  k_in = k_ff + 1'b1;
                  i_in = '0;
               end
            end else begin
               rd_en    = 1'b1;
               rd_addr  = PW'(i_ff);
               state_in = clkm_pkg::ST_KW_CMP;
            end
         end
         clkm_pkg::ST_KW_CMP: begin
            if (char_eq) begin
               i_in     = i_ff + 1'b1;
               state_in = clkm_pkg::ST_KW_CHECK;
            end else if (k_ff == clkm_pkg::KW_LAST) begin
               id_in    = clkm_pkg::UNKNOWN_ID;
               pos_in   = '0;
               state_in = clkm_pkg::ST_EMIT_READ;
            end else begin
               k_in     = k_ff + 1'b1;
               i_in     = '0;
               state_in = clkm_pkg::ST_KW_CHECK;
            end
         end
         clkm_pkg::ST_SKIP_CHECK: begin
            if (pos_ff >= len_ff) begin
               state_in = clkm_pkg::ST_EMPTY;
            end else begin
               rd_en    = 1'b1;
               state_in = clkm_pkg::ST_SKIP_CMP;
            end
         end
         clkm_pkg::ST_SKIP_CMP: begin
            if (is_blank) begin
               pos_in   = pos_ff + 1'b1;
               state_in = clkm_pkg::ST_SKIP_CHECK;
            end else begin
               state_in = clkm_pkg::ST_EMIT_READ;
            end
         end
         clkm_pkg::ST_EMIT_READ: begin
            rd_en    = 1'b1;
            state_in = clkm_pkg::ST_EMIT_LOAD;
         end
         clkm_pkg::ST_EMIT_LOAD: begin
            // read data holds until the output register frees up
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_char_in  = rd_data;
               rsp_cv_in    = 1'b1;
               rsp_last_in  = emit_last;
               pos_in       = pos_ff + 1'b1;
               cnt_in       = cnt_ff + 1'b1;
               state_in     = emit_last ? clkm_pkg::ST_IDLE : clkm_pkg::ST_EMIT_READ;
            end
         end
         clkm_pkg::ST_EMPTY: begin
            if (out_free) begin
               rsp_valid_in = 1'b1;
               rsp_id_in    = id_ff;
               rsp_char_in  = clkm_pkg::CHAR_NUL;
               rsp_cv_in    = 1'b0;
               rsp_last_in  = 1'b1;
               state_in     = clkm_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = clkm_pkg::ST_IDLE;
         end
      endcase
   end

   assign busy           = (state_ff != clkm_pkg::ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_command_id = rsp_id_ff;
   assign rsp_arg_char   = rsp_char_ff;
   assign rsp_char_valid = rsp_cv_ff;
   assign rsp_last       = rsp_last_ff;

   a_empty_is_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && !rsp_cv_ff |-> rsp_last_ff)
      else $error("empty argument item not marked last");

   a_start_when_idle: assert property (@(posedge clock) disable iff (reset)
      start |-> state_ff == clkm_pkg::ST_IDLE)
      else $error("line start while sequencer busy");

   a_cmp_after_read: assert property (@(posedge clock) disable iff (reset)
      state_ff == clkm_pkg::ST_KW_CMP |-> $past(state_ff) == clkm_pkg::ST_KW_CHECK)
      else $error("keyword compare without a store read");

   a_id_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff |-> rsp_id_ff <= clkm_pkg::UNKNOWN_ID)
      else $error("command id out of range");

endmodule

`default_nettype wire

// ----- tb/command_line_keyword_matcher_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_keyword_matcher_checker
// Watches the byte and result channels of the keyword matcher, rebuilds each
// text line from the accepted bytes, works out the command and argument items
// that every line end should produce, and compares them in order with the
// items the block hands out.
// ----------------------------------------------------------------------------
module command_line_keyword_matcher_checker (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   input  logic                         req_stall,
   input  logic [7:0]                   req_rx_byte,
   input  logic                         rsp_valid,
   input  logic                         rsp_stall,
   input  logic [clkm_pkg::ID_W-1:0]    rsp_command_id,
   input  logic [7:0]                   rsp_arg_char,
   input  logic                         rsp_char_valid,
   input  logic                         rsp_last,
   output int                           mismatch_count,
   output int                           pending_count,
   output int                           lines_parsed,
   output int                           items_checked,
   output int                           empty_args_seen
);

   typedef enum logic [clkm_pkg::ID_W-1:0] {
      CMD_IDN,
      CMD_LED,
      CMD_STEP_DELAY,
      CMD_STEP_INIT,
      CMD_HELP,
      CMD_UNKNOWN
   } command_type;

   typedef struct packed {
      logic [clkm_pkg::ID_W-1:0] id;
      logic [7:0]                ch;
      logic                      char_valid;
      logic                      last;
   } arg_item_type;

   logic [7:0]   line_buf [0:clkm_pkg::LINE_CAPACITY-1];
   int           fill;
   arg_item_type expected_args [$];

   function automatic string keyword_of(input int k);
      case (k)
         CMD_IDN:        return "*IDN?";
         CMD_LED:        return "LED";
         CMD_STEP_DELAY: return "STEP:DELAY";
         CMD_STEP_INIT:  return "STEP:INIT";
         CMD_HELP:       return "HELP";
         default:        return "";
      endcase
   endfunction

   // only ASCII letters fold
   function automatic logic [7:0] upcase(input logic [7:0] c);
      return (c >= "a" && c <= "z") ? c - 8'd32 : c;
   endfunction

   // Matches the collected line and queues the items it should produce.
   function automatic void parse_line(input int len);
      command_type  id;
      int           start;
      int           count;
      string        kw;
      bit           hit;
      arg_item_type item;
      id    = CMD_UNKNOWN;
      start = 0;
      for (int k = 0; k < CMD_UNKNOWN && id == CMD_UNKNOWN; k++) begin
         kw  = keyword_of(k);
         hit = (kw.len() <= len);
         for (int i = 0; i < kw.len() && hit; i++) begin
            if (upcase(line_buf[i]) != upcase(kw[i])) hit = 0;
         end
         if (hit) begin
            id    = command_type'(k);
            start = kw.len();
            while (start < len && (line_buf[start] == clkm_pkg::CHAR_SPACE ||
                                   line_buf[start] == clkm_pkg::CHAR_TAB))
               start++;
         end
      end
      count = len - start;
      if (count == 0) begin
         item = '{id: id, ch: 8'd0, char_valid: 1'b0, last: 1'b1};
         expected_args.push_back(item);
      end else begin
         if (count > clkm_pkg::MAX_RESULTS) count = clkm_pkg::MAX_RESULTS;
         for (int i = 0; i < count; i++) begin
            item = '{id: id, ch: line_buf[start + i], char_valid: 1'b1,
                     last: (i == count - 1)};
            expected_args.push_back(item);
         end
      end
   endfunction

   function automatic void take_byte(input logic [7:0] b);
      if (b == clkm_pkg::CHAR_LF || b == clkm_pkg::CHAR_CR ||
          b == clkm_pkg::CHAR_NUL) begin
         if (fill > 0) begin
            parse_line(fill);
            lines_parsed++;
         end
         fill = 0;
      end else begin
         line_buf[fill] = b;
         fill++;
         // store filled up: the line is dropped without a result
         if (fill == clkm_pkg::LINE_CAPACITY) fill = 0;
      end
   endfunction

   function automatic void check_item();
      arg_item_type seen;
      arg_item_type want;
      seen = '{id: rsp_command_id, ch: rsp_arg_char, char_valid: rsp_char_valid,
               last: rsp_last};
      items_checked++;
      if (expected_args.size() == 0) begin
         mismatch_count++;
         if (mismatch_count <= 10)
            $display("%t: unexpected item id=%0d char=%02h valid=%b last=%b",
                     $realtime, seen.id, seen.ch, seen.char_valid, seen.last);
      end else begin
         want = expected_args.pop_front();
         if (!want.char_valid) empty_args_seen++;
         if (seen.id !== want.id || seen.ch !== want.ch ||
             seen.char_valid !== want.char_valid || seen.last !== want.last) begin
            mismatch_count++;
            if (mismatch_count <= 10)
               $display("%t: item mismatch exp id=%0d char=%02h valid=%b last=%b%s",
                        $realtime, want.id, want.ch, want.char_valid, want.last,
                        $sformatf(" got id=%0d char=%02h valid=%b last=%b",
                                  seen.id, seen.ch, seen.char_valid, seen.last));
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         fill            = 0;
         mismatch_count  = 0;
         lines_parsed    = 0;
         items_checked   = 0;
         empty_args_seen = 0;
         expected_args.delete();
      end else begin
         if (req_valid && !req_stall) take_byte(req_rx_byte);
         if (rsp_valid && !rsp_stall) check_item();
      end
      pending_count = expected_args.size();
   end

endmodule

// ----- tb/command_line_keyword_matcher_unit_test.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// command_line_keyword_matcher_unit_test
// Feeds the keyword matcher with directed lines (keywords in mixed case,
// glued arguments, blank runs, empty lines and arguments, bytes above 127),
// then with random lines, mostly well formed, while both channels pause at
// random. A checker beside the block predicts and compares every item.
// ----------------------------------------------------------------------------
module command_line_keyword_matcher_unit_test;

   typedef enum int {
      LK_WELL_FORMED,
      LK_GLUED,
      LK_TRUNCATED,
      LK_NOISE,
      LK_LONG
   } line_kind_type;

   localparam int RANDOM_BYTES = 200;

   logic                      clock       = 1'b0;
   logic                      reset       = 1'b1;
   logic                      req_valid   = 1'b0;
   logic [7:0]                req_rx_byte = 8'd0;
   logic                      rsp_stall   = 1'b0;
   logic                      req_stall;
   logic                      rsp_valid;
   logic [clkm_pkg::ID_W-1:0] rsp_command_id;
   logic [7:0]                rsp_arg_char;
   logic                      rsp_char_valid;
   logic                      rsp_last;

   int         mismatch_count;
   int         pending_count;
   int         lines_parsed;
   int         items_checked;
   int         empty_args_seen;
   int         send_gap_pct = 0;
   int         rsp_hold_pct = 0;
   int         bytes_sent   = 0;
   logic [7:0] line_bytes [$];

   command_line_keyword_matcher_unit dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_rx_byte    (req_rx_byte),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_command_id (rsp_command_id),
      .rsp_arg_char   (rsp_arg_char),
      .rsp_char_valid (rsp_char_valid),
      .rsp_last       (rsp_last)
   );

   command_line_keyword_matcher_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_command_id  (rsp_command_id),
      .rsp_arg_char    (rsp_arg_char),
      .rsp_char_valid  (rsp_char_valid),
      .rsp_last        (rsp_last),
      .mismatch_count  (mismatch_count),
      .pending_count   (pending_count),
      .lines_parsed    (lines_parsed),
      .items_checked   (items_checked),
      .empty_args_seen (empty_args_seen)
   );

   initial begin
      forever #1 clock = ~clock;
   end

   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99, 0) < rsp_hold_pct);
   end

   initial begin
      #2_000_000;
      $display("watchdog expired with %0d items outstanding", pending_count);
      $display("CHECKS FAILED");
      $finish;
   end

   function automatic string keyword_text(input int k);
      case (k)
         0:       return "*IDN?";
         1:       return "LED";
         2:       return "STEP:DELAY";
         3:       return "STEP:INIT";
         default: return "HELP";
      endcase
   endfunction

   function automatic logic [7:0] pick_end_mark();
      case ($urandom_range(2, 0))
         0:       return clkm_pkg::CHAR_LF;
         1:       return clkm_pkg::CHAR_CR;
         default: return clkm_pkg::CHAR_NUL;
      endcase
   endfunction

   // any byte that does not end the line, mostly printable
   function automatic logic [7:0] pick_text_char();
      logic [7:0] c;
      if ($urandom_range(3, 0) != 0) return 8'($urandom_range(126, 33));
      do c = 8'($urandom_range(255, 0));
      while (c == clkm_pkg::CHAR_LF || c == clkm_pkg::CHAR_CR ||
             c == clkm_pkg::CHAR_NUL);
      return c;
   endfunction

   function automatic logic [7:0] mix_case(input logic [7:0] c);
      if (((c >= "A" && c <= "Z") || (c >= "a" && c <= "z")) && $urandom_range(1, 0))
         return c ^ 8'h20;
      return c;
   endfunction

   function automatic logic [7:0] pick_blank();
      return $urandom_range(1, 0) ? clkm_pkg::CHAR_SPACE : clkm_pkg::CHAR_TAB;
   endfunction

   // stall is sampled mid-cycle, so it is the value the next rising edge sees
   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99, 0) < send_gap_pct) begin
         req_valid   <= 1'b0;
         req_rx_byte <= 8'($urandom);
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      @(negedge clock);
      while (req_stall) @(negedge clock);
      @(posedge clock);
      bytes_sent++;
   endtask

   task automatic send_text(input string s, input logic [7:0] mark);
      for (int i = 0; i < s.len(); i++) send_byte(s[i]);
      send_byte(mark);
   endtask

   task automatic send_random_line(input line_kind_type kind, input int fill_to);
      string kw;
      int    n;
      kw = keyword_text($urandom_range(4, 0));
      line_bytes.delete();
      case (kind)
         LK_WELL_FORMED, LK_GLUED, LK_LONG: begin
            for (int i = 0; i < kw.len(); i++) line_bytes.push_back(mix_case(kw[i]));
            if (kind == LK_GLUED) begin
               line_bytes.push_back(8'($urandom_range(126, 33)));
            end else begin
               n = (kind == LK_LONG) ? 1 : $urandom_range(3, 0);
               repeat (n) line_bytes.push_back(pick_blank());
            end
            n = (kind == LK_LONG) ? fill_to - line_bytes.size() : $urandom_range(8, 0);
            repeat (n) line_bytes.push_back(pick_text_char());
         end
         LK_TRUNCATED: begin
            n = $urandom_range(kw.len() - 1, 1);
            for (int i = 0; i < n; i++) line_bytes.push_back(mix_case(kw[i]));
            repeat ($urandom_range(4, 0)) line_bytes.push_back(pick_text_char());
         end
         default: begin
            repeat ($urandom_range(12, 0)) line_bytes.push_back(pick_text_char());
         end
      endcase
      foreach (line_bytes[i]) send_byte(line_bytes[i]);
      send_byte(pick_end_mark());
   endtask

   initial begin
      int            random_start;
      int            done;
      int            line_no;
      int            pick;
      int            wait_cycles;
      line_kind_type kind;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed lines
      send_text("led", clkm_pkg::CHAR_CR);
      send_text("LEDX 5", clkm_pkg::CHAR_LF);
      send_text("*idn?", clkm_pkg::CHAR_NUL);
      send_byte(clkm_pkg::CHAR_CR);                     // empty line
      send_text("HeLp \t ", clkm_pkg::CHAR_LF);         // blanks only after keyword
      send_text("step:init\t\t42", clkm_pkg::CHAR_CR);
      send_text("Step:Delay 1000", clkm_pkg::CHAR_LF);
      send_text("STEP:DELA", clkm_pkg::CHAR_LF);        // keyword cut short
      send_text("LE", clkm_pkg::CHAR_NUL);
      send_byte(8'hFF);
      send_byte(8'h80);
      send_byte(8'h7F);
      send_byte(8'h01);
      send_byte(clkm_pkg::CHAR_LF);

      // random lines, three idling phases
      random_start = bytes_sent;
      line_no      = 0;
      done         = 0;
      while (done < RANDOM_BYTES) begin
         if (done < RANDOM_BYTES / 3) begin
            send_gap_pct = 18;
            rsp_hold_pct = 72;
         end else if (done < 2 * RANDOM_BYTES / 3) begin
            send_gap_pct = 72;
            rsp_hold_pct = 18;
         end else begin
            send_gap_pct = 0;
            rsp_hold_pct = 0;
         end
         pick = $urandom_range(99, 0);
         if (pick < 60)      kind = LK_WELL_FORMED;
         else if (pick < 70) kind = LK_GLUED;
         else if (pick < 80) kind = LK_TRUNCATED;
         else if (pick < 90) kind = LK_NOISE;
         else                kind = LK_LONG;
         // longest line that fits, then one that just fills the store
         if (line_no == 0)
            send_random_line(LK_LONG, clkm_pkg::LINE_CAPACITY - 1);
         else if (line_no == 1)
            send_random_line(LK_LONG, clkm_pkg::LINE_CAPACITY);
         else
            send_random_line(kind, $urandom_range(80, 50));
         line_no++;
         done = bytes_sent - random_start;
      end
      req_valid <= 1'b0;

      wait_cycles = 0;
      while (pending_count != 0 && wait_cycles < 50_000) begin
         @(posedge clock);
         wait_cycles++;
      end
      repeat (300) @(posedge clock);

      $display("%0d bytes sent, %0d lines parsed, %0d argument items checked",
               bytes_sent, lines_parsed, items_checked);
      $display("%0d empty arguments seen, %0d items never arrived",
               empty_args_seen, pending_count);
      if (mismatch_count == 0 && pending_count == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule

// ----- files.f -----
rtl/clkm_pkg.sv
rtl/clkm_store.sv
rtl/clkm_seq.sv
rtl/command_line_keyword_matcher_unit.sv
tb/command_line_keyword_matcher_checker.sv
tb/command_line_keyword_matcher_unit_test.sv
